// ----- design/assert_macros.svh -----
// assertion macros used by the sorted set engine datapath (sse_dp)
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define SSE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define SSE_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- design/sse_pkg.sv -----
// shared types and constants for the sorted set engine
// no dependencies; used by sse_ctrl, sse_dp and sorted_set_engine
package sse_pkg;

    localparam int DEF_CAPACITY = 256;

    localparam logic [2:0] MODE_INSERT   = 3'd0;
    localparam logic [2:0] MODE_REMOVE   = 3'd1;
    localparam logic [2:0] MODE_CONTAINS = 3'd2;
    localparam logic [2:0] MODE_GET      = 3'd3;
    localparam logic [2:0] MODE_CLEAR    = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [63:0] value;
        logic [7:0]         rank;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic signed [63:0] read_value;
        logic [8:0]         entry_count;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic srch_rd;
        logic srch_cmp;
        logic up_init;
        logic dn_init;
        logic up_step;
        logic dn_step;
        logic place;
        logic get_rd;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       open;
        logic       hit;
        logic       found;
        logic       full;
        logic       up_more;
        logic       dn_more;
        logic       rank_ok;
    } t_sts;

endpackage

// ----- design/sse_ctrl.sv -----
// sequencing state machine of the sorted set engine
// depends on sse_pkg; drives commands into sse_dp and owns the result valid
module sse_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    input  sse_pkg::t_sts i_sts,
    output sse_pkg::t_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_DISPATCH = 10'b00_0000_0010,
        S_SEARCH   = 10'b00_0000_0100,
        S_COMPARE  = 10'b00_0000_1000,
        S_DECIDE   = 10'b00_0001_0000,
        S_SHIFT_UP = 10'b00_0010_0000,
        S_SHIFT_DN = 10'b00_0100_0000,
        S_PLACE    = 10'b00_1000_0000,
        S_GET      = 10'b01_0000_0000,
        S_RESULT   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_rsp_valid;
    logic   n_rsp_valid;
    logic   out_free;

    assign out_free    = !r_rsp_valid || i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (i_sts.mode == sse_pkg::MODE_INSERT ||
                             i_sts.mode == sse_pkg::MODE_REMOVE ||
                             i_sts.mode == sse_pkg::MODE_CONTAINS) begin
                    n_state = S_SEARCH;
                end else if (i_sts.mode == sse_pkg::MODE_GET) begin
                    n_state = S_GET;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_SEARCH: begin
                if (i_sts.open) begin
                    o_cmd.srch_rd = 1'b1;
                    n_state       = S_COMPARE;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_COMPARE: begin
                o_cmd.srch_cmp = 1'b1;
                n_state        = i_sts.hit ? S_DECIDE : S_SEARCH;
            end
            S_DECIDE: begin
                priority if (i_sts.mode == sse_pkg::MODE_INSERT && !i_sts.found &&
                             !i_sts.full) begin
                    o_cmd.up_init = 1'b1;
                    n_state       = S_SHIFT_UP;
                end else if (i_sts.mode == sse_pkg::MODE_REMOVE && i_sts.found) begin
                    o_cmd.dn_init = 1'b1;
                    n_state       = S_SHIFT_DN;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_SHIFT_UP: begin
                if (i_sts.up_more) begin
                    o_cmd.up_step = 1'b1;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_SHIFT_DN: begin
                if (i_sts.dn_more) begin
                    o_cmd.dn_step = 1'b1;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_RESULT;
            end
            S_GET: begin
                o_cmd.get_rd = i_sts.rank_ok;
                n_state      = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (o_cmd.finish) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule

// ----- design/sse_dp.sv -----
// datapath of the sorted set engine: entry store, search window, shift pointer, result
// depends on sse_pkg and assert_macros.svh; commanded by sse_ctrl
`include "assert_macros.svh"

module sse_dp #(
    parameter int CAPACITY = sse_pkg::DEF_CAPACITY
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sse_pkg::t_req i_req,
    input  sse_pkg::t_cmd i_cmd,
    output sse_pkg::t_sts o_sts,
    output sse_pkg::t_rsp o_rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = (CW > 8) ? CW : 8;
    localparam int EW = (CW > 9) ? CW : 9;

    logic [63:0]        r_mem [CAPACITY];
    logic signed [63:0] r_rd_data;

    logic [2:0]         r_mode;
    logic signed [63:0] r_value;
    logic [7:0]         r_rank;
    logic [CW-1:0]      r_lo;
    logic [CW-1:0]      r_hi;
    logic [CW-1:0]      r_ptr;
    logic [IW-1:0]      r_mid;
    logic               r_found;
    logic [CW-1:0]      r_count;
    logic               r_wp_valid;
    logic [IW-1:0]      r_wp_addr;
    sse_pkg::t_rsp      r_rsp;

    logic [CW-1:0]      mid_full;
    logic [IW-1:0]      n_mid;
    logic [CW-1:0]      mid_ext;
    logic [CW-1:0]      ptr_dec;
    logic [CW-1:0]      ptr_inc;
    logic [CW-1:0]      wp_ext;
    logic               hit;
    logic               below;
    logic               full;
    logic               rank_ok;

    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [63:0]        wr_data;

    logic [1:0]         n_status;
    logic               n_found;
    logic signed [63:0] n_read;
    logic [CW-1:0]      n_count;
    logic [EW-1:0]      count_e;
    sse_pkg::t_rsp      n_rsp;

    assign mid_full = r_lo + ((r_hi - r_lo) >> 1);
    assign n_mid    = mid_full[IW-1:0];
    assign mid_ext  = CW'(r_mid);
    assign ptr_dec  = r_ptr - CW'(1);
    assign ptr_inc  = r_ptr + CW'(1);
    assign wp_ext   = CW'(r_wp_addr);
    assign hit      = (r_rd_data == r_value);
    assign below    = (r_rd_data < r_value);
    assign full     = (r_count == CW'(CAPACITY));
    assign rank_ok  = (KW'(r_rank) < KW'(r_count));

    assign o_sts.mode    = r_mode;
    assign o_sts.open    = (r_lo < r_hi);
    assign o_sts.hit     = hit;
    assign o_sts.found   = r_found;
    assign o_sts.full    = full;
    assign o_sts.up_more = (r_ptr > r_lo);
    assign o_sts.dn_more = (ptr_inc < r_count);
    assign o_sts.rank_ok = rank_ok;

    // one read and one write of the store per cycle
    always_comb begin
        rd_en   = i_cmd.srch_rd | i_cmd.up_step | i_cmd.dn_step | i_cmd.get_rd;
        rd_addr = IW'(r_rank);
        priority if (i_cmd.srch_rd) begin
            rd_addr = n_mid;
        end else if (i_cmd.up_step) begin
            rd_addr = ptr_dec[IW-1:0];
        end else if (i_cmd.dn_step) begin
            rd_addr = ptr_inc[IW-1:0];
        end else begin
            rd_addr = IW'(r_rank);
        end
        wr_en   = r_wp_valid | i_cmd.place;
        wr_addr = r_wp_valid ? r_wp_addr : r_lo[IW-1:0];
        wr_data = r_wp_valid ? r_rd_data : r_value;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= $signed(r_mem[rd_addr]);
        end
    end

    // result and new count
    always_comb begin
        n_status = sse_pkg::ST_OK;
        n_found  = 1'b0;
        n_read   = '0;
        n_count  = r_count;
        unique case (r_mode)
            sse_pkg::MODE_INSERT: begin
                if (r_found) begin
                    n_found = 1'b1;
                end else if (full) begin
                    n_status = sse_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            sse_pkg::MODE_REMOVE: begin
                if (r_found) begin
                    n_found = 1'b1;
                    n_count = r_count - CW'(1);
                end else begin
                    n_status = sse_pkg::ST_MISS;
                end
            end
            sse_pkg::MODE_CONTAINS: begin
                if (r_found) begin
                    n_found = 1'b1;
                end else begin
                    n_status = sse_pkg::ST_MISS;
                end
            end
            sse_pkg::MODE_GET: begin
                if (rank_ok) begin
                    n_read = r_rd_data;
                end else begin
                    n_status = sse_pkg::ST_MISS;
                end
            end
            sse_pkg::MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        count_e           = EW'(n_count);
        n_rsp.status      = n_status;
        n_rsp.found       = n_found;
        n_rsp.read_value  = n_read;
        n_rsp.entry_count = count_e[8:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_wp_valid <= 1'b0;
        end else begin
            r_wp_valid <= i_cmd.up_step | i_cmd.dn_step;
            if (i_cmd.finish) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_req.mode;
            r_value <= i_req.value;
            r_rank  <= i_req.rank;
            r_lo    <= '0;
            r_hi    <= r_count;
            r_found <= 1'b0;
        end
        if (i_cmd.srch_rd) begin
            r_mid <= n_mid;
        end
        if (i_cmd.srch_cmp) begin
            if (hit) begin
                r_found <= 1'b1;
                r_lo    <= mid_ext;
            end else if (below) begin
                r_lo <= mid_ext + CW'(1);
            end else begin
                r_hi <= mid_ext;
            end
        end
        if (i_cmd.up_init) begin
            r_ptr <= r_count;
        end else if (i_cmd.dn_init) begin
            r_ptr <= r_lo;
        end else if (i_cmd.up_step) begin
            r_ptr <= ptr_dec;
        end else if (i_cmd.dn_step) begin
            r_ptr <= ptr_inc;
        end
        if (i_cmd.up_step | i_cmd.dn_step) begin
            r_wp_addr <= r_ptr[IW-1:0];
        end
        if (i_cmd.finish) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

    `SSE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY), "count above capacity")
    `SSE_ASSERT_NEVER(a_one_write, i_clk, i_rst_n, r_wp_valid && i_cmd.place, "two store writes")
    `SSE_ASSERT(a_shift_range, i_clk, i_rst_n, r_wp_valid |-> (wp_ext <= r_count), "shift out of range")
    `SSE_ASSERT(a_count_hold, i_clk, i_rst_n, !i_cmd.finish |=> $stable(r_count), "count moved mid request")

endmodule

// ----- design/sorted_set_engine.sv -----
// channel   | valid       | ready       | payload
// request   | i_req_valid | o_req_ready | i_req (sse_pkg::t_req)
// result    | o_rsp_valid | i_rsp_ready | o_rsp (sse_pkg::t_rsp)
//
// one request at a time; a result register lets the next request in while a result waits
// insert and remove, when they change the set: a binary search, then a shift of the entries
// above the position, one entry at a time through the one-read one-write entry store
// contains: the binary search alone; get: one store read; clear and unused modes: no store access
// synchronous active-low reset empties the set at once; the store needs no clearing pass
// a stalled result holds the engine in its final step until the result is taken
// top level of the sorted set engine; depends on sse_pkg, sse_ctrl and sse_dp
module sorted_set_engine #(
    parameter int CAPACITY = sse_pkg::DEF_CAPACITY
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  sse_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output sse_pkg::t_rsp o_rsp
);

    sse_pkg::t_cmd cmd;
    sse_pkg::t_sts sts;

    sse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sse_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

endmodule
